// ===== design/u8ld_pkg.sv =====
// Shared types, constants and the byte classifier of the UTF-8 line decoder.
package u8ld_pkg;

  // Byte codes and masks used by the decoder.
  localparam logic [7:0] CR_BYTE    = 8'h0D;
  localparam logic [7:0] LF_BYTE    = 8'h0A;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [1:0] CONT_PREFIX = 2'b10;

  localparam int unsigned CP_W = 21;

  // One input item after classification.
  typedef struct packed {
    logic       end_of_stream;
    logic [7:0] data_byte;
    logic [2:0] lead_len;
    logic       is_cr;
    logic       is_lf;
  } item_t;

  // One decoded character.
  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            line_end;
    logic            malformed;
  } res_t;

  // Request from the sequencer to the output stage for one processing step.
  typedef struct packed {
    logic step;
    logic has_res;
    logic final_step;
    res_t res;
  } emit_req_t;

  // Classify a raw byte: sequence length opened by it and the special codes.
  function automatic item_t classify(input logic [7:0] b, input logic eos);
    item_t it;
    it.end_of_stream = eos;
    it.data_byte     = b;
    if ((b & LEAD4_MASK) == LEAD4_CODE) begin
      it.lead_len = 3'd4;
    end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
      it.lead_len = 3'd3;
    end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
      it.lead_len = 3'd2;
    end else begin
      it.lead_len = 3'd1;
    end
    it.is_cr = (b == CR_BYTE);
    it.is_lf = (b == LF_BYTE);
    return it;
  endfunction

endpackage

// ===== design/utf8_line_decoder.sv =====
// Top level of the UTF-8 line decoder: input queue, sequencer and output stage.
//
//   Channel  Direction  Payload
//   in_      slave      tdata[7:0] data_byte, tuser end_of_stream
//   out_     master     tdata[20:0] code_point, tuser[0] line_end,
//                       tuser[1] malformed, tlast last_of_run
//
// The sequencer takes one byte or end item per cycle unless the output holds it,
// so plain bytes and good sequences sustain one transfer per cycle. The held bytes
// after the lead of a failed sequence (up to three) are decoded again before the
// next input item; a last result that follows a held one stalls the sequencer.
// Reset is synchronous and clears only control state; there is no clearing pass.
// A two-entry input queue and the output register let either side stall alone.
module utf8_line_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tuser,   // end_of_stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // code_point, zero fill
  output logic [1:0]  out_tuser,  // line_end, malformed
  output logic        out_tlast   // last_of_run
);
  import u8ld_pkg::*;

  logic      head_valid;
  item_t     head;
  logic      pop;
  logic      emit_ready;
  emit_req_t req;

  u8ld_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  u8ld_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .emit_ready (emit_ready),
    .req        (req)
  );

  u8ld_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .emit_ready (emit_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== design/u8ld_front.sv =====
// Input side: accepts items, classifies them and queues them for the sequencer.
module u8ld_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [7:0]     in_tdata,   // data_byte
  input  logic           in_tuser,   // end_of_stream
  output logic           head_valid,
  output u8ld_pkg::item_t head,
  input  logic           pop
);
  import u8ld_pkg::*;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned PTR_W  = $clog2(QDEPTH);
  localparam int unsigned CNT_W  = $clog2(QDEPTH + 1);

  item_t            queue_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push;

  assign in_tready  = (cnt_r != CNT_W'(QDEPTH));
  assign push       = in_tvalid && in_tready;
  assign head_valid = (cnt_r != '0);
  assign head       = queue_r[rd_ptr_r];

  // Pointer and fill count update for one transfer in and one pop out.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage; classified on the way in.
  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= classify(in_tdata, in_tuser);
    end
  end

endmodule

// ===== design/u8ld_back.sv =====
// Sequencer: holds open sequences, checks them and replays bytes of failed ones.
module u8ld_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  u8ld_pkg::item_t     head,
  output logic                pop,
  input  logic                emit_ready,
  output u8ld_pkg::emit_req_t req
);
  import u8ld_pkg::*;

  logic [7:0] held_r [4];
  logic [7:0] held_nxt [4];
  logic [2:0] cnt_r, cnt_nxt;
  logic [2:0] slen_r, slen_nxt;
  logic [7:0] rq_r [3];
  logic [7:0] rq_nxt [3];
  logic [1:0] rq_cnt_r, rq_cnt_nxt;

  logic       from_rq;
  logic       go;
  item_t      cur;
  logic [7:0] rem [3];
  logic [1:0] rem_cnt;
  logic [7:0] h [4];
  logic [2:0] new_cnt;
  logic       ok;
  logic [CP_W-1:0] cp;
  res_t       res;
  logic       has_res;

  assign from_rq = (rq_cnt_r != 2'd0);
  assign go      = (from_rq || head_valid) && emit_ready;
  assign pop     = go && !from_rq;
  assign cur     = from_rq ? classify(rq_r[0], 1'b0) : head;

  // Replay bytes left once the front one is taken.
  assign rem[0]  = rq_r[1];
  assign rem[1]  = rq_r[2];
  assign rem[2]  = 8'h00;
  assign rem_cnt = from_rq ? rq_cnt_r - 2'd1 : 2'd0;

  // Held bytes with the current byte placed at the next free entry.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      h[i] = held_r[i];
    end
    h[cnt_r[1:0]] = cur.data_byte;
  end

  assign new_cnt = cnt_r + 3'd1;

  // Continuation prefix check and code point assembly by sequence length.
  always_comb begin
    ok = (h[1][7:6] == CONT_PREFIX);
    cp = '0;
    case (slen_r)
      3'd2: begin
        cp = {10'd0, h[0][4:0], h[1][5:0]};
      end
      3'd3: begin
        ok = ok && (h[2][7:6] == CONT_PREFIX);
        cp = {5'd0, h[0][3:0], h[1][5:0], h[2][5:0]};
      end
      3'd4: begin
        ok = ok && (h[2][7:6] == CONT_PREFIX) && (h[3][7:6] == CONT_PREFIX);
        cp = {h[0][2:0], h[1][5:0], h[2][5:0], h[3][5:0]};
      end
      default: begin
        cp = '0;
      end
    endcase
  end

  // One processing step of a byte or an end item.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      held_nxt[i] = held_r[i];
    end
    for (int i = 0; i < 3; i++) begin
      rq_nxt[i] = rem[i];
    end
    cnt_nxt    = cnt_r;
    slen_nxt   = slen_r;
    rq_cnt_nxt = rem_cnt;
    has_res    = 1'b0;
    res        = '0;
    if (cur.end_of_stream) begin
      // A pending lead goes out alone; partial continuations are dropped.
      if (slen_r != 3'd0) begin
        has_res       = 1'b1;
        res.code_point = {13'd0, held_r[0]};
        res.malformed  = 1'b1;
      end
      cnt_nxt  = 3'd0;
      slen_nxt = 3'd0;
    end else if (slen_r == 3'd0) begin
      if (cur.lead_len > 3'd1) begin
        held_nxt[0] = cur.data_byte;
        cnt_nxt     = 3'd1;
        slen_nxt    = cur.lead_len;
      end else if (!cur.is_cr) begin
        has_res        = 1'b1;
        res.code_point = {13'd0, cur.data_byte};
        res.line_end   = cur.is_lf;
      end
    end else begin
      for (int i = 0; i < 4; i++) begin
        held_nxt[i] = h[i];
      end
      cnt_nxt = new_cnt;
      if (new_cnt == slen_r) begin
        has_res  = 1'b1;
        cnt_nxt  = 3'd0;
        slen_nxt = 3'd0;
        if (ok) begin
          res.code_point = cp;
        end else begin
          // Failed sequence: lead passes through, the rest is decoded again first.
          res.code_point = {13'd0, h[0]};
          res.malformed  = 1'b1;
          rq_cnt_nxt     = rem_cnt + 2'(slen_r - 3'd1);
          case (slen_r)
            3'd2: begin
              rq_nxt[0] = h[1];
              rq_nxt[1] = rem[0];
              rq_nxt[2] = rem[1];
            end
            3'd3: begin
              rq_nxt[0] = h[1];
              rq_nxt[1] = h[2];
              rq_nxt[2] = rem[0];
            end
            default: begin
              rq_nxt[0] = h[1];
              rq_nxt[1] = h[2];
              rq_nxt[2] = h[3];
            end
          endcase
        end
      end
    end
  end

  assign req.step       = go;
  assign req.has_res    = has_res;
  assign req.final_step = (rq_cnt_nxt == 2'd0);
  assign req.res        = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 3'd0;
      slen_r   <= 3'd0;
      rq_cnt_r <= 2'd0;
    end else if (go) begin
      cnt_r    <= cnt_nxt;
      slen_r   <= slen_nxt;
      rq_cnt_r <= rq_cnt_nxt;
    end
  end

  // Held and replay bytes carry no reset; they are read only once written.
  always_ff @(posedge clk) begin
    if (go) begin
      for (int i = 0; i < 4; i++) begin
        held_r[i] <= held_nxt[i];
      end
      for (int i = 0; i < 3; i++) begin
        rq_r[i] <= rq_nxt[i];
      end
    end
  end

endmodule

// ===== design/u8ld_emit.sv =====
// Output stage: holds one result back until it is known whether it ends its item.
module u8ld_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  u8ld_pkg::emit_req_t req,
  output logic                emit_ready,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [23:0]         out_tdata,   // code_point, zero fill
  output logic [1:0]          out_tuser,   // line_end, malformed
  output logic                out_tlast    // last_of_run
);
  import u8ld_pkg::*;

  logic out_valid_r, out_valid_nxt;
  res_t out_res_r, out_res_nxt;
  logic out_last_r, out_last_nxt;
  logic pend_valid_r, pend_valid_nxt;
  logic pend_closed_r, pend_closed_nxt;
  res_t pend_res_r, pend_res_nxt;
  logic out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign emit_ready = out_free && !(pend_valid_r && pend_closed_r);

  // Route step results through the pending slot to the output register.
  always_comb begin
    out_valid_nxt   = out_valid_r && !out_tready;
    out_res_nxt     = out_res_r;
    out_last_nxt    = out_last_r;
    pend_valid_nxt  = pend_valid_r;
    pend_closed_nxt = pend_closed_r;
    pend_res_nxt    = pend_res_r;
    if (pend_valid_r && pend_closed_r) begin
      // A closed pending result ends its item.
      if (out_free) begin
        out_valid_nxt  = 1'b1;
        out_res_nxt    = pend_res_r;
        out_last_nxt   = 1'b1;
        pend_valid_nxt = 1'b0;
      end
    end else if (req.step) begin
      if (req.has_res && pend_valid_r) begin
        // Earlier result is not the last; the new one waits.
        out_valid_nxt   = 1'b1;
        out_res_nxt     = pend_res_r;
        out_last_nxt    = 1'b0;
        pend_res_nxt    = req.res;
        pend_closed_nxt = req.final_step;
      end else if (req.has_res && req.final_step) begin
        out_valid_nxt = 1'b1;
        out_res_nxt   = req.res;
        out_last_nxt  = 1'b1;
      end else if (req.has_res) begin
        pend_valid_nxt  = 1'b1;
        pend_closed_nxt = 1'b0;
        pend_res_nxt    = req.res;
      end else if (req.final_step && pend_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_res_nxt    = pend_res_r;
        out_last_nxt   = 1'b1;
        pend_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      pend_valid_r  <= 1'b0;
      pend_closed_r <= 1'b0;
    end else begin
      out_valid_r   <= out_valid_nxt;
      pend_valid_r  <= pend_valid_nxt;
      pend_closed_r <= pend_closed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    out_last_r <= out_last_nxt;
    pend_res_r <= pend_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, out_res_r.code_point};
  assign out_tuser  = {out_res_r.malformed, out_res_r.line_end};
  assign out_tlast  = out_last_r;

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the UTF-8 line decoder with a class-based scoreboard.
module tb;
  import u8ld_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // data_byte
  logic        in_tuser;   // end_of_stream
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // code_point, zero fill
  logic [1:0]  out_tuser;  // line_end, malformed
  logic        out_tlast;  // last_of_run

  // One decoded character as it should leave the block.
  typedef struct {
    logic [CP_W-1:0] code_point;
    logic            line_end;
    logic            malformed;
    logic            last_of_run;
  } char_rec_t;

  // Tracks the decoder state and holds the characters still owed by the block.
  class decode_ledger;
    logic [7:0]  held [4];
    int unsigned held_count;
    int unsigned seq_len;
    char_rec_t   pending_chars[$];
    int unsigned failures;

    function new();
      held_count = 0;
      seq_len    = 0;
      failures   = 0;
    endfunction

    function void add_char(logic [CP_W-1:0] cp, logic lf, logic mal);
      char_rec_t c;
      c.code_point  = cp;
      c.line_end    = lf;
      c.malformed   = mal;
      c.last_of_run = 1'b0;
      pending_chars.push_back(c);
    endfunction

    // Decodes one accepted input transfer and queues the characters it yields.
    function void note_byte(logic [7:0] b, logic eos);
      logic [7:0]      replay[$];
      logic [7:0]      cur;
      int unsigned     len;
      int unsigned     start;
      logic            ok;
      logic [CP_W-1:0] cp;
      start = pending_chars.size();
      if (eos) begin
        // A pending lead byte is flushed alone; held continuations are lost.
        if (seq_len != 0 && held_count != 0) add_char({13'd0, held[0]}, 1'b0, 1'b1);
        held_count = 0;
        seq_len    = 0;
      end else begin
        replay.push_back(b);
        while (replay.size() > 0) begin
          cur = replay.pop_front();
          if (seq_len == 0) begin
            if ((cur & LEAD4_MASK) == LEAD4_CODE) len = 4;
            else if ((cur & LEAD3_MASK) == LEAD3_CODE) len = 3;
            else if ((cur & LEAD2_MASK) == LEAD2_CODE) len = 2;
            else len = 1;
            if (len > 1) begin
              held[0]    = cur;
              held_count = 1;
              seq_len    = len;
            end else if (cur != CR_BYTE) begin
              add_char({13'd0, cur}, cur == LF_BYTE, 1'b0);
            end
            continue;
          end
          if (held_count < 4) begin
            held[held_count] = cur;
            held_count++;
          end
          if (held_count >= seq_len) begin
            ok = 1'b1;
            for (int i = 1; i < seq_len && i < 4; i++)
              if (held[i][7:6] != CONT_PREFIX) ok = 1'b0;
            if (ok) begin
              case (seq_len)
                2: cp = {10'd0, held[0][4:0], held[1][5:0]};
                3: cp = {5'd0, held[0][3:0], held[1][5:0], held[2][5:0]};
                default: cp = {held[0][2:0], held[1][5:0], held[2][5:0], held[3][5:0]};
              endcase
              add_char(cp, 1'b0, 1'b0);
            end else begin
              // The lead goes out alone and the rest is decoded again in order.
              add_char({13'd0, held[0]}, 1'b0, 1'b1);
              for (int i = held_count - 1; i >= 1; i--) replay.push_front(held[i]);
            end
            held_count = 0;
            seq_len    = 0;
          end
        end
      end
      if (pending_chars.size() > start) pending_chars[$].last_of_run = 1'b1;
    endfunction

    // Compares one accepted output transfer with the oldest owed character.
    function void check_char(logic [CP_W-1:0] cp, logic lf, logic mal, logic last);
      char_rec_t e;
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected character: expected none, got code point %h", $time, cp);
        failures++;
        return;
      end
      e = pending_chars.pop_front();
      if (cp !== e.code_point) begin
        $display("%0t: code_point: expected %h, got %h", $time, e.code_point, cp);
        failures++;
      end
      if (lf !== e.line_end) begin
        $display("%0t: line_end: expected %b, got %b", $time, e.line_end, lf);
        failures++;
      end
      if (mal !== e.malformed) begin
        $display("%0t: malformed: expected %b, got %b", $time, e.malformed, mal);
        failures++;
      end
      if (last !== e.last_of_run) begin
        $display("%0t: last_of_run: expected %b, got %b", $time, e.last_of_run, last);
        failures++;
      end
    endfunction
  endclass

  decode_ledger ledger;
  logic         send_gaps;
  logic         sink_stalls;
  int           items_sent;

  utf8_line_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Clock with a period of ten time units.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly no gap, some short ones and the odd long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  // Offers one item from a falling edge and holds it until the transfer.
  task automatic send_item(input logic [7:0] b, input logic eos);
    int gap;
    gap = send_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    in_tuser  = eos;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    ledger.note_byte(b, eos);
    items_sent++;
    @(negedge clk);
  endtask

  // Mostly well-formed sequences with random payload, plus noise and broken ones.
  task automatic send_random_chunk();
    int         r;
    int         len;
    int         cut;
    int         bad;
    logic [7:0] seq [4];
    r = $urandom_range(0, 99);
    if (r < 6) begin
      send_item(8'($urandom_range(0, 255)), 1'b1);
    end else if (r < 22) begin
      send_item(8'($urandom_range(0, 255)), 1'b0);
    end else if (r < 28) begin
      send_item(r[0] ? LF_BYTE : CR_BYTE, 1'b0);
    end else begin
      len = $urandom_range(2, 4);
      case (len)
        2: seq[0] = LEAD2_CODE | 8'($urandom_range(0, 31));
        3: seq[0] = LEAD3_CODE | 8'($urandom_range(0, 15));
        default: seq[0] = LEAD4_CODE | 8'($urandom_range(0, 7));
      endcase
      for (int i = 1; i < len; i++) seq[i] = {CONT_PREFIX, 6'($urandom_range(0, 63))};
      if ($urandom_range(0, 99) < 18) begin
        bad = $urandom_range(1, len - 1);
        case ($urandom_range(0, 3))
          0: seq[bad] = LF_BYTE;
          1: seq[bad] = CR_BYTE;
          default: seq[bad] = 8'($urandom_range(0, 255));
        endcase
      end
      cut = len;
      if ($urandom_range(0, 99) < 6) cut = $urandom_range(1, len - 1);
      for (int i = 0; i < cut; i++) send_item(seq[i], 1'b0);
      if (cut < len) send_item(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  // Result side: ready changes at the falling edge, with random stalls.
  initial begin
    int stall_left;
    out_tready = 1'b0;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else begin
        out_tready = 1'b1;
        if (sink_stalls) stall_left = pick_gap();
      end
    end
  end

  // Every output transfer is checked at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      ledger.check_char(out_tdata[CP_W-1:0], out_tuser[0], out_tuser[1], out_tlast);
  end

  // Stimulus: reset, directed cases, random blocks with varying idling, then drain.
  initial begin
    int blk;
    int blk_end;
    ledger      = new();
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = 8'h00;
    in_tuser    = 1'b0;
    send_gaps   = 1'b0;
    sink_stalls = 1'b0;
    items_sent  = 0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // Plain bytes at the extremes, stray bytes, carriage return and line feed.
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hF8, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(CR_BYTE, 1'b0);
    send_item(LF_BYTE, 1'b0);
    // Good two-, three- and four-byte sequences, the last at the top value.
    send_item(8'hC2, 1'b0); send_item(8'hA9, 1'b0);
    send_item(8'hE2, 1'b0); send_item(8'h82, 1'b0); send_item(8'hAC, 1'b0);
    send_item(8'hF7, 1'b0); send_item(8'hBF, 1'b0); send_item(8'hBF, 1'b0);
    send_item(8'hBF, 1'b0);
    // Line feed inside a sequence, then a failure that replays three plain bytes.
    send_item(8'hE2, 1'b0); send_item(LF_BYTE, 1'b0); send_item(8'h41, 1'b0);
    send_item(8'hF0, 1'b0); send_item(8'h41, 1'b0); send_item(8'h42, 1'b0);
    send_item(8'h43, 1'b0);
    // A replayed lead that fails on a carriage return.
    send_item(8'hF0, 1'b0); send_item(8'hC2, 1'b0); send_item(CR_BYTE, 1'b0);
    send_item(8'h41, 1'b0);
    // End of stream with a partial sequence open, then with nothing open.
    send_item(8'hE2, 1'b0); send_item(8'h82, 1'b0); send_item(8'h5A, 1'b1);
    send_item(8'hA5, 1'b1);

    // Random blocks, cycling through the idling combinations.
    blk = 0;
    while (items_sent < 380) begin
      send_gaps   = (blk % 4 == 1) || (blk % 4 == 2);
      sink_stalls = (blk % 4 == 1) || (blk % 4 == 3);
      blk_end = items_sent + 60;
      while (items_sent < blk_end) send_random_chunk();
      blk++;
    end
    in_tvalid = 1'b0;

    while (ledger.pending_chars.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (ledger.failures == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5000000;
    $display("FAIL");
    $finish;
  end

endmodule
